### design/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk and disabled during reset.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sitda_pkg.sv
//------------------------------------------------------------------------------
// sitda_pkg
// Shared widths, character codes and the status type for the integer-to-text block.
//------------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

  localparam int VALUE_W  = 32;
  localparam int DIGITS   = 10;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int STEP_W   = 5;
  localparam int LEFT_W   = 4;
  localparam int CHAR_W   = 6;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

  // Status from the converter to the sequencer
  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } dab_stat_t;

endpackage

`default_nettype wire

### design/sitda_dabble.sv
//------------------------------------------------------------------------------
// sitda_dabble
// Iterative binary-to-BCD converter: one shift-and-add-3 step per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module sitda_dabble (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [sitda_pkg::VALUE_W-1:0] mag,
  output sitda_pkg::dab_stat_t               stat
);

  logic [sitda_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [sitda_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [sitda_pkg::BCD_W-1:0]   adj;
  logic [sitda_pkg::STEP_W-1:0]  step_r;
  logic                          run_r;
  logic                          done_r;

  // Add 3 to every digit of 5 or more, then shift one bit in
  always_comb begin
    for (int d = 0; d < sitda_pkg::DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
    bcd_nxt = {adj[sitda_pkg::BCD_W-2:0], bin_r[sitda_pkg::VALUE_W-1]};
    bin_nxt = {bin_r[sitda_pkg::VALUE_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == sitda_pkg::LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin_r <= mag;
      bcd_r <= '0;
    end else if (run_r) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign stat.done = done_r;
  assign stat.bcd  = bcd_r;

endmodule

`default_nettype wire

### design/signed_int_to_decimal_ascii.sv
//------------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per result.
//------------------------------------------------------------------------------
// Pulse start with in_value while busy is low to hand over one item. The block
// raises busy, takes the magnitude, and converts it to ten BCD digits with a
// shift-and-add-3 unit that runs one step per cycle, 32 steps in all. It then
// drops leading zero digits one per cycle (up to nine), sends '-' first for a
// negative value, and sends the digits most significant first, one per cycle.
// Each character shows on out_character for exactly one cycle with out_valid
// high; out_last_char marks the final one. The receiver cannot stall, so it
// must take every character in the cycle it appears. An item occupies the
// block through the conversion, the zero skip and the step that leaves it,
// and the characters; busy falls as the last character is registered, so a
// new item may be taken while that character is still out.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module signed_int_to_decimal_ascii (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [sitda_pkg::VALUE_W-1:0] in_value,
  output      logic                          out_valid,
  output      logic [sitda_pkg::CHAR_W-1:0]  out_character,
  output      logic                          out_last_char
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t                        state_r;
  logic                          neg_r;
  logic [sitda_pkg::BCD_W-1:0]   digits_r;
  logic [sitda_pkg::LEFT_W-1:0]  left_r;
  logic                          out_valid_r;
  logic [sitda_pkg::CHAR_W-1:0]  out_character_r;
  logic                          out_last_char_r;

  logic                          accept;
  logic [sitda_pkg::VALUE_W-1:0] mag;
  logic [3:0]                    top_digit;
  sitda_pkg::dab_stat_t          dab_stat;

  assign accept    = start && (state_r == ST_IDLE);
  // Two's complement magnitude; the most negative value wraps to 2^31, which fits
  assign mag       = in_value[sitda_pkg::VALUE_W-1] ? (~in_value + 1'b1) : in_value;
  assign top_digit = digits_r[sitda_pkg::BCD_W-1 -: 4];

  sitda_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .mag   (mag),
    .stat  (dab_stat)
  );

  // Sequencer: wait for the converter, strip leading zeros, then emit the text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      neg_r           <= 1'b0;
      left_r          <= '0;
      digits_r        <= '0;
      out_character_r <= '0;
      out_last_char_r <= 1'b0;
    end else begin
      out_valid_r     <= 1'b0;
      out_last_char_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            neg_r   <= in_value[sitda_pkg::VALUE_W-1];
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (dab_stat.done) begin
            digits_r <= dab_stat.bcd;
            left_r   <= sitda_pkg::LEFT_W'(sitda_pkg::DIGITS);
            state_r  <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // Drop zero digits from the top, but always keep the units digit
          if (top_digit == 4'd0 && left_r != 4'd1) begin
            digits_r <= {digits_r[sitda_pkg::BCD_W-5:0], 4'd0};
            left_r   <= left_r - 1'b1;
          end else if (neg_r) begin
            state_r <= ST_SIGN;
          end else begin
            state_r <= ST_DIGIT;
          end
        end
        ST_SIGN: begin
          out_valid_r     <= 1'b1;
          out_character_r <= sitda_pkg::CH_MINUS;
          state_r         <= ST_DIGIT;
        end
        ST_DIGIT: begin
          out_valid_r     <= 1'b1;
          out_character_r <= sitda_pkg::CH_ZERO + {2'b00, top_digit};
          out_last_char_r <= (left_r == 4'd1);
          digits_r        <= {digits_r[sitda_pkg::BCD_W-5:0], 4'd0};
          left_r          <= left_r - 1'b1;
          if (left_r == 4'd1) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last_char = out_last_char_r;

  // The sign never ends a number
  `ASSERT_SAME(a_sign_not_last, out_valid && out_character == sitda_pkg::CH_MINUS, !out_last_char, "minus sign flagged as last character")
  // Only '-' or a digit ever leaves the block
  `ASSERT_SAME(a_char_legal, out_valid, out_character == sitda_pkg::CH_MINUS || (out_character >= sitda_pkg::CH_ZERO && out_character <= sitda_pkg::CH_ZERO + 6'd9), "illegal character code")
  // After the last character of a number, nothing follows at once
  `ASSERT_NEXT(a_gap_after_last, out_valid && out_last_char, !out_valid, "character right after end of number")
  // Accepting an item raises busy, and no character goes out right after accept
  `ASSERT_NEXT(a_busy_after_start, start && !busy, busy && !out_valid, "block idle or emitting right after accept")

endmodule

`default_nettype wire
